/* sv/see_pkg.sv */
// shared types, constants and opcodes of the stack expression evaluator
package see_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int VAL_W       = 32;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_POW  = 8'h5e;
    localparam logic [7:0] CH_MUL  = 8'h2a;
    localparam logic [7:0] CH_DIV  = 8'h2f;
    localparam logic [7:0] CH_ADD  = 8'h2b;
    localparam logic [7:0] CH_SUB  = 8'h2d;

    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_POW  = 3'd5;

    typedef struct packed {
        logic [2:0]       op;
        logic [VAL_W-1:0] operand;
        logic             last;
    } t_cmd;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             over;
        logic             under;
        logic             arith;
    } t_result;

endpackage

/* sv/stack_expression_evaluator_unit.sv */
// top level of the stack expression evaluator
//  channel | dir | tdata                         | tuser
//  s_axis  | in  | [7:0] char_code               | -     (tlast = last_char)
//  m_axis  | out | [31:0] value                  | [0] overflow [1] underflow [2] arith
//  cfg     | in  | order_mode on i_cfg_wdata     | -
// back end per request: an operand is pushed directly; an operator pops two entries, runs the ALU, pushes the result
// the final character adds the S_FIN and S_OUT states; the divider and power loop set the worst case
// a 4-entry command queue lets input run ahead; a waiting result stalls the back end
// synchronous active-low reset clears stack count, flags and order_mode
module stack_expression_evaluator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // value
    output logic [2:0]  m_axis_tuser    // overflow_seen, underflow_seen, arith_error
);
    logic             r_mode;
    logic             w_cvalid, w_cready;
    see_pkg::t_cmd    w_cmd;
    see_pkg::t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mode <= 1'b0;
        else if (i_cfg_we) r_mode <= i_cfg_wdata;
    end

    see_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_char      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_cmd_valid (w_cvalid),
        .i_cmd_ready (w_cready),
        .o_cmd       (w_cmd)
    );

    see_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_mode),
        .i_cmd_valid (w_cvalid),
        .o_cmd_ready (w_cready),
        .i_cmd       (w_cmd),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (w_res)
    );

    assign m_axis_tdata = w_res.value;
    assign m_axis_tuser = {w_res.arith, w_res.under, w_res.over};
endmodule

/* sv/see_front.sv */
// front end: classifies characters into commands and queues them
module see_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_char,
    input  logic              i_last,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output see_pkg::t_cmd     o_cmd
);
    see_pkg::t_cmd           r_mem [see_pkg::Q_DEPTH];
    logic [see_pkg::Q_AW-1:0] r_wp, r_rp;
    logic [see_pkg::Q_AW:0]   r_cnt;
    see_pkg::t_cmd           w_cmd;
    logic                    w_push, w_pop;

    always_comb begin
        w_cmd.last    = i_last;
        w_cmd.operand = {24'd0, i_char} - {24'd0, see_pkg::CH_ZERO};
        case (i_char)
            see_pkg::CH_POW: w_cmd.op = see_pkg::OP_POW;
            see_pkg::CH_MUL: w_cmd.op = see_pkg::OP_MUL;
            see_pkg::CH_DIV: w_cmd.op = see_pkg::OP_DIV;
            see_pkg::CH_ADD: w_cmd.op = see_pkg::OP_ADD;
            see_pkg::CH_SUB: w_cmd.op = see_pkg::OP_SUB;
            default:         w_cmd.op = see_pkg::OP_PUSH;
        endcase
    end

    assign o_ready     = (r_cnt != see_pkg::Q_DEPTH[see_pkg::Q_AW:0]);
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {{see_pkg::Q_AW{1'b0}}, w_push}
                           - {{see_pkg::Q_AW{1'b0}}, w_pop};
        end
    end
endmodule

/* sv/see_alu.sv */
// multi-cycle arithmetic unit: wrap add/sub/mul, restoring divide, square-and-multiply power
module see_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [2:0]        i_op,
    input  logic [31:0]       i_x,
    input  logic [31:0]       i_y,
    output logic              o_done,
    output logic [31:0]       o_res,
    output logic              o_arith
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_POW  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]  r_st;
    logic [31:0] r_a, r_b, r_q, r_rem, r_res;
    logic [5:0]  r_cnt;
    logic        r_neg, r_arith;
    logic [32:0] w_trial;
    logic [31:0] w_mx, w_my;

    assign w_mx    = i_x[31] ? (32'd0 - i_x) : i_x;
    assign w_my    = i_y[31] ? (32'd0 - i_y) : i_y;
    assign w_trial = {r_rem, r_q[31]} - {1'b0, r_b};
    assign o_done  = (r_st == S_DONE);
    assign o_res   = r_res;
    assign o_arith = r_arith;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_start) begin
                        case (i_op)
                            see_pkg::OP_ADD: begin
                                r_res   <= i_x + i_y;
                                r_arith <= 1'b0;
                                r_st    <= S_DONE;
                            end
                            see_pkg::OP_SUB: begin
                                r_res   <= i_x - i_y;
                                r_arith <= 1'b0;
                                r_st    <= S_DONE;
                            end
                            see_pkg::OP_MUL: begin
                                r_res   <= i_x * i_y;
                                r_arith <= 1'b0;
                                r_st    <= S_DONE;
                            end
                            see_pkg::OP_DIV: begin
                                if (i_y == '0) begin
                                    r_res   <= '0;
                                    r_arith <= 1'b1;
                                    r_st    <= S_DONE;
                                end else begin
                                    r_q     <= w_mx;
                                    r_b     <= w_my;
                                    r_rem   <= '0;
                                    r_neg   <= i_x[31] ^ i_y[31];
                                    r_cnt   <= 6'd32;
                                    r_arith <= 1'b0;
                                    r_st    <= S_DIV;
                                end
                            end
                            see_pkg::OP_POW: begin
                                if (i_y[31]) begin
                                    r_arith <= (i_x == '0);
                                    r_st    <= S_DONE;
                                    if (i_x == 32'd1) r_res <= 32'd1;
                                    else if (i_x == 32'hffff_ffff)
                                        r_res <= i_y[0] ? 32'hffff_ffff : 32'd1;
                                    else r_res <= '0;
                                end else begin
                                    r_res   <= 32'd1;
                                    r_a     <= i_x;
                                    r_b     <= i_y;
                                    r_arith <= 1'b0;
                                    r_st    <= S_POW;
                                end
                            end
                            default: begin
                                r_res   <= i_x;
                                r_arith <= 1'b0;
                                r_st    <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt - 6'd1;
                    if (!w_trial[32]) begin
                        r_rem <= w_trial[31:0];
                        r_q   <= {r_q[30:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[30:0], r_q[31]};
                        r_q   <= {r_q[30:0], 1'b0};
                    end
                    if (r_cnt == 6'd1) r_st <= S_DONE;
                end
                S_POW: begin
                    if (r_b == '0) begin
                        r_st <= S_DONE;
                    end else begin
                        if (r_b[0]) r_res <= r_res * r_a;
                        r_a <= r_a * r_a;
                        r_b <= {1'b0, r_b[31:1]};
                    end
                end
                S_DONE: r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
            if (r_st == S_DIV && r_cnt == 6'd1) begin
                r_res <= r_neg ? (32'd0 - {r_q[30:0], !w_trial[32]})
                               : {r_q[30:0], !w_trial[32]};
            end
        end
    end
endmodule

/* sv/see_back.sv */
// back end: stack sequencer with memory, error flags and output register
module see_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_mode,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  see_pkg::t_cmd     i_cmd,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output see_pkg::t_result  o_res
);
    localparam logic [2:0] S_FETCH = 3'd0;
    localparam logic [2:0] S_RD1   = 3'd1;
    localparam logic [2:0] S_RD2   = 3'd2;
    localparam logic [2:0] S_ALU   = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_PUSH  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [31:0]              r_mem [see_pkg::STACK_DEPTH];
    logic [31:0]              r_rdata;
    logic [2:0]               r_st;
    logic [see_pkg::SP_W-1:0] r_sp;
    see_pkg::t_cmd            r_cmd;
    logic [31:0]              r_t, r_val;
    logic                     r_tok, r_sok;
    logic                     r_over, r_under, r_arith;
    logic                     r_ovalid;
    see_pkg::t_result         r_out;
    logic                     w_alu_start, w_alu_done, w_alu_arith;
    logic [31:0]              w_alu_res, w_x, w_y, w_s;
    logic [see_pkg::SP_W-1:0] w_spm1;

    assign w_spm1      = r_sp - 1'b1;
    assign o_cmd_ready = (r_st == S_FETCH);
    assign o_res_valid = r_ovalid;
    assign o_res       = r_out;
    // second operand data is registered: it arrives in the cycle after its read address
    assign w_s         = r_sok ? r_rdata : '0;
    assign w_x         = i_mode ? r_t : w_s;
    assign w_y         = i_mode ? w_s : r_t;
    assign w_alu_start = (r_st == S_ALU);

    see_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_alu_start),
        .i_op    (r_cmd.op),
        .i_x     (w_x),
        .i_y     (w_y),
        .o_done  (w_alu_done),
        .o_res   (w_alu_res),
        .o_arith (w_alu_arith)
    );

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[w_spm1[see_pkg::ADDR_W-1:0]];
        if (r_st == S_PUSH && r_sp != see_pkg::STACK_DEPTH[see_pkg::SP_W-1:0]) begin
            r_mem[r_sp[see_pkg::ADDR_W-1:0]] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_FETCH;
            r_sp     <= '0;
            r_over   <= 1'b0;
            r_under  <= 1'b0;
            r_arith  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_res_ready && r_st != S_OUT) r_ovalid <= 1'b0;
            case (r_st)
                S_FETCH: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_val <= i_cmd.operand;
                        r_st  <= (i_cmd.op == see_pkg::OP_PUSH) ? S_PUSH : S_RD1;
                    end
                end
                S_RD1: begin
                    r_st <= S_RD2;
                    if (r_sp == '0) begin
                        r_tok   <= 1'b0;
                        r_under <= 1'b1;
                    end else begin
                        r_tok <= 1'b1;
                        r_sp  <= w_spm1;
                    end
                end
                S_RD2: begin
                    r_t  <= r_tok ? r_rdata : '0;
                    r_st <= S_ALU;
                    if (r_sp == '0) begin
                        r_sok   <= 1'b0;
                        r_under <= 1'b1;
                    end else begin
                        r_sok <= 1'b1;
                        r_sp  <= w_spm1;
                    end
                end
                S_ALU: begin
                    r_st <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_alu_done) begin
                        r_val   <= w_alu_res;
                        r_arith <= r_arith | w_alu_arith;
                        r_st    <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (r_sp == see_pkg::STACK_DEPTH[see_pkg::SP_W-1:0]) begin
                        r_over <= 1'b1;
                    end else begin
                        r_sp <= r_sp + 1'b1;
                    end
                    r_st <= r_cmd.last ? S_FIN : S_FETCH;
                end
                S_FIN: begin
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || i_res_ready) begin
                        r_out.value <= (r_sp == '0) ? '0 : r_rdata;
                        r_out.over  <= r_over;
                        r_out.under <= r_under | (r_sp == '0);
                        r_out.arith <= r_arith;
                        r_ovalid    <= 1'b1;
                        r_sp        <= '0;
                        r_over      <= 1'b0;
                        r_under     <= 1'b0;
                        r_arith     <= 1'b0;
                        r_st        <= S_FETCH;
                    end
                end
                default: r_st <= S_FETCH;
            endcase
        end
    end
endmodule

/* sv/see_checker.sv */
// port-level checker for the stack expression evaluator
module see_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    // final requests accepted and not yet answered
    logic [3:0] r_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_open <= '0;
        else r_open <= r_open + {3'd0, s_axis_tvalid && s_axis_tready && s_axis_tlast}
                              - {3'd0, m_axis_tvalid && m_axis_tready};
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_user_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tuser))
        else $error("flags changed while stalled");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_open != 4'd0)
        else $error("unexpected result");
endmodule

bind stack_expression_evaluator_unit see_checker u_see_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
